FILE: rtl/pva_pkg.sv
// Shared widths, request codes and the slot table entry layout for the voice allocator.
`default_nettype none

package pva_pkg;

    localparam int REQ_TYPE_W = 3;
    localparam int PRI_W      = 8;
    localparam int ENT_W      = 11;
    localparam int CH_W       = 9;
    localparam int SLOT_W     = 7;
    localparam int TIME_W     = 31;
    localparam int RES_W      = 8;
    localparam int CFG_W      = 8;

    localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC   = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_FIND    = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_LOCK    = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_UNLOCK  = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 3'd4;
    localparam logic [REQ_TYPE_W-1:0] REQ_REL_ALL = 3'd5;

    localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RST = 8'd128;
    localparam logic [RES_W-1:0] RES_NONE         = 8'hFF;

    typedef struct packed {
        logic                     active;
        logic                     locked;
        logic [PRI_W-1:0]         pri;
        logic [TIME_W-1:0]        last_use;
        logic signed [ENT_W-1:0]  entity;
        logic signed [CH_W-1:0]   channel;
    } t_slot_entry;

    // A released slot keeps no owner: entity and channel read as minus one.
    localparam t_slot_entry SLOT_RELEASED = '{
        active:   1'b0,
        locked:   1'b0,
        pri:      '0,
        last_use: '0,
        entity:   '1,
        channel:  '1
    };

endpackage

`default_nettype wire

FILE: rtl/pva_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/priority_voice_allocator.sv
// Top level of the priority voice allocator: slot table in RAM and a scanning sequencer.
// Scans read one slot per cycle; with n = min(active_slots, NUM_SLOTS), allocate, find and
// release-all scan n slots, allocate and find stopping early on a match; lock, unlock and
// release read and write the slot if in range; other codes and empty scans go straight to the result.
// One request is in work at a time; the input is ready again once the result is loaded.
// Synchronous active-low reset, then a clearing pass over all NUM_SLOTS slots with no requests taken.
`default_nettype none

module priority_voice_allocator #(
    parameter int NUM_SLOTS = 128
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,

    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [pva_pkg::CFG_W-1:0]             i_cfg_data,

    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [pva_pkg::REQ_TYPE_W-1:0]        i_req_type,
    input  wire logic [pva_pkg::PRI_W-1:0]             i_priority_req,
    input  wire logic signed [pva_pkg::ENT_W-1:0]      i_entity,
    input  wire logic signed [pva_pkg::CH_W-1:0]       i_channel,
    input  wire logic [pva_pkg::SLOT_W-1:0]            i_slot,
    input  wire logic [pva_pkg::TIME_W-1:0]            i_now,

    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [pva_pkg::RES_W-1:0]           o_result_slot,
    output logic                                       o_stolen
);

    import pva_pkg::*;

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int EW = $bits(t_slot_entry);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_RESP
    } t_state;

    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_active_slots, n_active_slots;
    logic [AW-1:0]            r_clr_idx, n_clr_idx;
    logic [REQ_TYPE_W-1:0]    r_req_type, n_req_type;
    logic [PRI_W-1:0]         r_pri, n_pri;
    logic signed [ENT_W-1:0]  r_ent, n_ent;
    logic signed [CH_W-1:0]   r_ch, n_ch;
    logic [SLOT_W-1:0]        r_slot, n_slot;
    logic [TIME_W-1:0]        r_now, n_now;
    logic [CW-1:0]            r_n, n_n;
    logic [CW-1:0]            r_issue, n_issue;
    logic                     r_dv, n_dv;
    logic [AW-1:0]            r_eval, n_eval;
    logic                     r_have_empty, n_have_empty;
    logic [AW-1:0]            r_empty, n_empty;
    logic                     r_have_vic, n_have_vic;
    logic [AW-1:0]            r_vic, n_vic;
    logic [PRI_W-1:0]         r_best_pri, n_best_pri;
    logic [TIME_W-1:0]        r_best_time, n_best_time;
    logic [RES_W-1:0]         r_res, n_res;
    logic                     r_stolen, n_stolen;
    logic                     r_o_valid, n_o_valid;
    logic [RES_W-1:0]         r_o_res, n_o_res;
    logic                     r_o_stolen, n_o_stolen;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    t_slot_entry              wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [EW-1:0]            rd_word;
    t_slot_entry              rd_entry;
    t_slot_entry              claim_entry;
    t_slot_entry              mod_entry;
    logic [CW-1:0]            scan_len;
    logic                     last_eval;
    logic                     owner_eq;

    pva_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word)
    );

    assign rd_entry = t_slot_entry'(rd_word);

    always_comb begin
        claim_entry          = SLOT_RELEASED;
        claim_entry.active   = 1'b1;
        claim_entry.pri      = r_pri;
        claim_entry.last_use = r_now;
        claim_entry.entity   = r_ent;
        claim_entry.channel  = r_ch;
    end

    always_comb begin
        if (int'(r_active_slots) < NUM_SLOTS) begin
            scan_len = CW'(r_active_slots);
        end else begin
            scan_len = CW'(NUM_SLOTS);
        end
    end

    assign last_eval = (CW'(r_eval) + CW'(1)) == r_n;
    assign owner_eq  = (rd_entry.entity == r_ent) && (rd_entry.channel == r_ch);

    always_comb begin
        n_state        = r_state;
        n_active_slots = r_active_slots;
        n_clr_idx      = r_clr_idx;
        n_req_type     = r_req_type;
        n_pri          = r_pri;
        n_ent          = r_ent;
        n_ch           = r_ch;
        n_slot         = r_slot;
        n_now          = r_now;
        n_n            = r_n;
        n_issue        = r_issue;
        n_dv           = 1'b0;
        n_eval         = r_eval;
        n_have_empty   = r_have_empty;
        n_empty        = r_empty;
        n_have_vic     = r_have_vic;
        n_vic          = r_vic;
        n_best_pri     = r_best_pri;
        n_best_time    = r_best_time;
        n_res          = r_res;
        n_stolen       = r_stolen;
        n_o_valid      = r_o_valid;
        n_o_res        = r_o_res;
        n_o_stolen     = r_o_stolen;
        wr_en          = 1'b0;
        wr_addr        = r_eval;
        wr_data        = claim_entry;
        rd_en          = 1'b0;
        rd_addr        = r_issue[AW-1:0];
        mod_entry      = rd_entry;

        if (i_cfg_valid) begin
            n_active_slots = i_cfg_data;
        end

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                wr_en     = 1'b1;
                wr_addr   = r_clr_idx;
                wr_data   = '0;
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(NUM_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_valid) begin
                    n_req_type   = i_req_type;
                    n_pri        = i_priority_req;
                    n_ent        = i_entity;
                    n_ch         = i_channel;
                    n_slot       = i_slot;
                    n_now        = i_now;
                    n_n          = scan_len;
                    n_issue      = '0;
                    n_have_empty = 1'b0;
                    n_have_vic   = 1'b0;
                    n_res        = RES_NONE;
                    n_stolen     = 1'b0;
                    case (i_req_type)
                        REQ_ALLOC, REQ_FIND, REQ_REL_ALL: begin
                            if (i_req_type == REQ_REL_ALL) begin
                                n_res = RES_W'(i_slot);
                            end
                            if (scan_len == '0) begin
                                n_state = ST_RESP;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        REQ_LOCK, REQ_UNLOCK, REQ_RELEASE: begin
                            n_res = RES_W'(i_slot);
                            if (int'(i_slot) < NUM_SLOTS) begin
                                n_state = ST_RMW_RD;
                            end else begin
                                n_state = ST_RESP;
                            end
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // Reads run one slot ahead of the evaluation of the returned entry.
                if (r_issue != r_n) begin
                    rd_en   = 1'b1;
                    n_issue = r_issue + CW'(1);
                    n_dv    = 1'b1;
                    n_eval  = r_issue[AW-1:0];
                end
                if (r_dv) begin
                    case (r_req_type)
                        REQ_ALLOC: begin
                            if (!rd_entry.locked) begin
                                if (!rd_entry.active && !r_have_empty) begin
                                    n_have_empty = 1'b1;
                                    n_empty      = r_eval;
                                end else if (rd_entry.pri < r_pri) begin
                                    if (!r_have_vic || (rd_entry.pri < r_best_pri) ||
                                        (rd_entry.last_use < r_best_time)) begin
                                        n_have_vic  = 1'b1;
                                        n_vic       = r_eval;
                                        n_best_pri  = rd_entry.pri;
                                        n_best_time = rd_entry.last_use;
                                    end
                                end
                            end
                            if (!rd_entry.locked && owner_eq && (r_ch != '0)) begin
                                wr_en    = 1'b1;
                                wr_addr  = r_eval;
                                wr_data  = claim_entry;
                                n_res    = RES_W'(r_eval);
                                n_stolen = rd_entry.active;
                                n_state  = ST_RESP;
                            end else if (last_eval) begin
                                n_state = ST_FIN;
                            end
                        end
                        REQ_FIND: begin
                            if (rd_entry.active && owner_eq) begin
                                n_res   = RES_W'(r_eval);
                                n_state = ST_RESP;
                            end else if (last_eval) begin
                                n_state = ST_RESP;
                            end
                        end
                        default: begin
                            if (!rd_entry.locked) begin
                                wr_en   = 1'b1;
                                wr_addr = r_eval;
                                wr_data = SLOT_RELEASED;
                            end
                            if (last_eval) begin
                                n_state = ST_RESP;
                            end
                        end
                    endcase
                end
            end

            ST_FIN: begin
                // With no free slot seen, a slot is stolen only if a lower-priority victim was found.
                if (r_have_empty) begin
                    wr_en   = 1'b1;
                    wr_addr = r_empty;
                    n_res   = RES_W'(r_empty);
                end else if (r_have_vic) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_vic;
                    n_res    = RES_W'(r_vic);
                    n_stolen = 1'b1;
                end
                n_state = ST_RESP;
            end

            ST_RMW_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_slot);
                n_state = ST_RMW_WR;
            end

            ST_RMW_WR: begin
                wr_addr = AW'(r_slot);
                case (r_req_type)
                    REQ_LOCK: begin
                        mod_entry.locked = 1'b1;
                        wr_en            = 1'b1;
                    end
                    REQ_UNLOCK: begin
                        mod_entry.locked = 1'b0;
                        wr_en            = 1'b1;
                    end
                    default: begin
                        mod_entry = SLOT_RELEASED;
                        wr_en     = !rd_entry.locked;
                    end
                endcase
                wr_data = mod_entry;
                n_state = ST_RESP;
            end

            ST_RESP: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_res    = r_res;
                    n_o_stolen = r_stolen;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req_type  <= n_req_type;
        r_pri       <= n_pri;
        r_ent       <= n_ent;
        r_ch        <= n_ch;
        r_slot      <= n_slot;
        r_now       <= n_now;
        r_n         <= n_n;
        r_eval      <= n_eval;
        r_empty     <= n_empty;
        r_vic       <= n_vic;
        r_best_pri  <= n_best_pri;
        r_best_time <= n_best_time;
        r_res       <= n_res;
        r_stolen    <= n_stolen;
        r_o_res     <= n_o_res;
        r_o_stolen  <= n_o_stolen;
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_active_slots <= ACTIVE_SLOTS_RST;
            r_clr_idx      <= '0;
            r_issue        <= '0;
            r_dv           <= 1'b0;
            r_have_empty   <= 1'b0;
            r_have_vic     <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_active_slots <= n_active_slots;
            r_clr_idx      <= n_clr_idx;
            r_issue        <= n_issue;
            r_dv           <= n_dv;
            r_have_empty   <= n_have_empty;
            r_have_vic     <= n_have_vic;
            r_o_valid      <= n_o_valid;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_o_valid;
    assign o_result_slot = r_o_res;
    assign o_stolen      = r_o_stolen;

endmodule

`default_nettype wire

FILE: rtl/pva_checker.sv
// Port-level checks for the priority voice allocator, bound to its top level.
`default_nettype none

module pva_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_ready,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic signed [7:0] o_result_slot,
    input wire logic              o_stolen
);

    // Reset drops any pending result.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A request transfer always makes the block busy in the next cycle.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input still ready right after a request transfer");

    // A new result is only loaded while no request can be taken.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result appeared while the block was idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_slot) && $stable(o_stolen))
        else $error("stalled result changed");

endmodule

bind priority_voice_allocator pva_checker u_pva_checker (.*);

`default_nettype wire
